@@ sv/constant_velocity_track_predictor_core_defines.svh @@
// Assertion macros shared by the checker of the track predictor core.
`ifndef CONSTANT_VELOCITY_TRACK_PREDICTOR_CORE_DEFINES_SVH
`define CONSTANT_VELOCITY_TRACK_PREDICTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CVTP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cvtp assertion failed");

// Next-cycle implication, disabled during reset.
`define CVTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cvtp assertion failed");

// Next-cycle implication that is also checked while reset is applied.
`define CVTP_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("cvtp assertion failed");

`endif

@@ sv/cvtp_pkg.sv @@
// Shared types, constants and helpers of the track predictor core.
package cvtp_pkg;

    localparam int MAX_STEPS = 64;
    localparam int STEP_W = $clog2(MAX_STEPS);
    localparam int VAR_W = 39;
    localparam logic [VAR_W-1:0] VAR_CAP = 39'h40_0000_0000;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [15:0] CONF_ONE = 16'hFFFF;
    localparam int IN_W = 320;
    localparam int OUT_W = 232;

    typedef enum logic [2:0] {
        REG_STEP_TIME    = 3'd0,
        REG_STEP_DUR     = 3'd1,
        REG_RESULT_COUNT = 3'd2,
        REG_ACCEL_X      = 3'd3,
        REG_ACCEL_Y      = 3'd4,
        REG_CEILING      = 3'd5,
        REG_DECAY        = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] step_time;
        logic [31:0] step_dur;
        logic [6:0]  result_count;
        logic [31:0] accel_x;
        logic [31:0] accel_y;
        logic [31:0] ceiling;
        logic [15:0] decay;
    } cfg_t;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [15:0] cpos;
        logic [15:0] cvel;
        logic [62:0] stamp;
    } desc_t;

    function automatic logic [VAR_W-1:0] sat_var(input logic [VAR_W:0] v);
        if (v > {1'b0, VAR_CAP}) begin
            return VAR_CAP;
        end
        return v[VAR_W-1:0];
    endfunction

endpackage

@@ sv/cvtp_div.sv @@
// Restoring divider giving a 16-bit fraction quotient, one bit per cycle.
module cvtp_div
    import cvtp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] rem_init,
    input  logic [31:0] den,
    output logic        done,
    output logic [15:0] quo
);

    logic [32:0] r_reg;
    logic [15:0] q_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] sh;

    assign sh = {r_reg[31:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            r_reg    <= {1'b0, rem_init};
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (sh >= {1'b0, den}) begin
                r_reg <= sh - {1'b0, den};
                q_reg <= {q_reg[14:0], 1'b1};
            end else begin
                r_reg <= sh;
                q_reg <= {q_reg[14:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

@@ sv/cvtp_front.sv @@
// Front end: takes object beats and works out steps and confidences.
module cvtp_front
    import cvtp_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  cfg_t            cfg,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    output logic            q_push,
    output desc_t           q_data,
    input  logic            q_full
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_SUM, ST_MEAN, ST_CLASS, ST_DIV, ST_PUSH
    } state_t;

    typedef enum logic [3:0] {
        OP_DX, OP_DY, OP_DT2, OP_DT3, OP_DT4, OP_T1X, OP_T1Y,
        OP_T2X, OP_T2Y, OP_T3X, OP_T3Y
    } op_t;

    state_t state_reg;
    op_t    op_reg;
    logic [1:0] ph_reg;

    logic            in_valid_reg;
    logic [IN_W-1:0] in_data_reg;

    logic [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [31:0] vpx_reg, vpy_reg, vvx_reg, vvy_reg;
    logic [62:0] stamp_reg;

    logic [VAR_W-1:0] prod_reg [0:10];
    logic [51:0] plo_reg, phi_reg;
    logic [VAR_W-1:0] pxx_reg, pyy_reg, pvx_reg, pvy_reg;
    logic [VAR_W-1:0] mp_reg, mv_reg;
    logic lo_p_reg, hi_p_reg, lo_v_reg, hi_v_reg;

    logic [VAR_W-1:0] op_a;
    logic [31:0] op_b;
    logic [19:0] mul_x;
    logic [51:0] mul_p;
    logic [71:0] full;
    logic [55:0] q56;
    logic [VAR_W-1:0] qsat;
    logic [47:0] dfull;
    logic        neg;
    logic        div_start;
    logic        div_p_done, div_v_done;
    logic [15:0] quo_p, quo_v;
    logic [VAR_W:0] mean_p_sum, mean_v_sum;

    assign s_tready = !in_valid_reg;

    always_comb begin
        op_a = '0;
        op_b = '0;
        neg  = 1'b0;
        case (op_reg)
            OP_DX: begin
                op_a = {7'b0, vx_reg};
                op_b = cfg.step_time;
                neg  = vx_reg[31];
            end
            OP_DY: begin
                op_a = {7'b0, vy_reg};
                op_b = cfg.step_time;
                neg  = vy_reg[31];
            end
            OP_DT2: begin
                op_a = {7'b0, cfg.step_time};
                op_b = cfg.step_time;
            end
            OP_DT3: begin
                op_a = prod_reg[OP_DT2];
                op_b = cfg.step_time;
            end
            OP_DT4: begin
                op_a = prod_reg[OP_DT3];
                op_b = cfg.step_time;
            end
            OP_T1X: begin
                op_a = prod_reg[OP_DT2];
                op_b = vvx_reg;
            end
            OP_T1Y: begin
                op_a = prod_reg[OP_DT2];
                op_b = vvy_reg;
            end
            OP_T2X: begin
                op_a = prod_reg[OP_DT4];
                op_b = cfg.accel_x;
            end
            OP_T2Y: begin
                op_a = prod_reg[OP_DT4];
                op_b = cfg.accel_y;
            end
            OP_T3X: begin
                op_a = prod_reg[OP_DT2];
                op_b = cfg.accel_x;
            end
            OP_T3Y: begin
                op_a = prod_reg[OP_DT2];
                op_b = cfg.accel_y;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_x = (ph_reg == 2'd0) ? op_a[19:0] : {1'b0, op_a[38:20]};
    assign mul_p = {32'b0, mul_x} * {20'b0, op_b};
    assign full  = {phi_reg, 20'b0} + {20'b0, plo_reg};
    assign q56   = full[71:16];
    assign qsat  = (q56 > {17'b0, VAR_CAP}) ? VAR_CAP : q56[VAR_W-1:0];
    assign dfull = full[47:0] - (neg ? {cfg.step_time[15:0], 32'b0} : 48'b0);

    assign mean_p_sum = {1'b0, pxx_reg} + {1'b0, pyy_reg};
    assign mean_v_sum = {1'b0, pvx_reg} + {1'b0, pvy_reg};

    assign div_start = (state_reg == ST_CLASS);

    cvtp_div u_div_p (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (cfg.ceiling - mp_reg[31:0]),
        .den      (cfg.ceiling - ONE_Q16),
        .done     (div_p_done),
        .quo      (quo_p)
    );

    cvtp_div u_div_v (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (cfg.ceiling - mv_reg[31:0]),
        .den      (cfg.ceiling - ONE_Q16),
        .done     (div_v_done),
        .quo      (quo_v)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_valid_reg <= 1'b0;
            op_reg       <= OP_DX;
            ph_reg       <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= s_tdata;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid_reg) begin
                        px_reg       <= in_data_reg[31:0];
                        py_reg       <= in_data_reg[63:32];
                        vx_reg       <= in_data_reg[95:64];
                        vy_reg       <= in_data_reg[127:96];
                        vpx_reg      <= in_data_reg[159:128];
                        vpy_reg      <= in_data_reg[191:160];
                        vvx_reg      <= in_data_reg[223:192];
                        vvy_reg      <= in_data_reg[255:224];
                        stamp_reg    <= in_data_reg[318:256];
                        in_valid_reg <= 1'b0;
                        op_reg       <= OP_DX;
                        ph_reg       <= '0;
                        state_reg    <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    case (ph_reg)
                        2'd0: begin
                            plo_reg <= mul_p;
                            ph_reg  <= 2'd1;
                        end
                        2'd1: begin
                            phi_reg <= mul_p;
                            ph_reg  <= 2'd2;
                        end
                        default: begin
                            if (op_reg == OP_DX || op_reg == OP_DY) begin
                                prod_reg[op_reg] <= {7'b0, dfull[47:16]};
                            end else begin
                                prod_reg[op_reg] <= qsat;
                            end
                            ph_reg <= 2'd0;
                            if (op_reg == OP_T3Y) begin
                                state_reg <= ST_SUM;
                            end else begin
                                op_reg <= op_t'(op_reg + 4'd1);
                            end
                        end
                    endcase
                end
                ST_SUM: begin
                    pxx_reg <= sat_var({8'b0, vpx_reg} + {1'b0, prod_reg[OP_T1X]}
                                       + {3'b0, prod_reg[OP_T2X][VAR_W-1:2]});
                    pyy_reg <= sat_var({8'b0, vpy_reg} + {1'b0, prod_reg[OP_T1Y]}
                                       + {3'b0, prod_reg[OP_T2Y][VAR_W-1:2]});
                    pvx_reg <= sat_var({8'b0, vvx_reg} + {1'b0, prod_reg[OP_T3X]});
                    pvy_reg <= sat_var({8'b0, vvy_reg} + {1'b0, prod_reg[OP_T3Y]});
                    state_reg <= ST_MEAN;
                end
                ST_MEAN: begin
                    mp_reg    <= mean_p_sum[VAR_W:1];
                    mv_reg    <= mean_v_sum[VAR_W:1];
                    state_reg <= ST_CLASS;
                end
                ST_CLASS: begin
                    lo_p_reg  <= mp_reg <= {7'b0, ONE_Q16};
                    hi_p_reg  <= mp_reg >= {7'b0, cfg.ceiling};
                    lo_v_reg  <= mv_reg <= {7'b0, ONE_Q16};
                    hi_v_reg  <= mv_reg >= {7'b0, cfg.ceiling};
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_p_done && div_v_done) begin
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!q_full) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign q_push = (state_reg == ST_PUSH) && !q_full;

    always_comb begin
        q_data.px    = px_reg;
        q_data.py    = py_reg;
        q_data.dx    = prod_reg[OP_DX][31:0];
        q_data.dy    = prod_reg[OP_DY][31:0];
        q_data.vx    = vx_reg;
        q_data.vy    = vy_reg;
        q_data.cpos  = lo_p_reg ? CONF_ONE : (hi_p_reg ? 16'd0 : quo_p);
        q_data.cvel  = lo_v_reg ? CONF_ONE : (hi_v_reg ? 16'd0 : quo_v);
        q_data.stamp = stamp_reg;
    end

endmodule

@@ sv/cvtp_queue.sv @@
// Two-entry queue of object descriptors between front and back end.
module cvtp_queue
    import cvtp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t wdata,
    output logic  full,
    output logic  valid,
    output desc_t rdata,
    input  logic  pop
);

    desc_t      mem_reg [0:1];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_reg] <= wdata;
                wr_reg          <= !wr_reg;
            end
            if (pop) begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign rdata = mem_reg[rd_reg];

endmodule

@@ sv/cvtp_back.sv @@
// Back end: plays out the run of predictions for one object, one beat per cycle while the output is not stalled.
module cvtp_back
    import cvtp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             q_valid,
    input  desc_t            q_data,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    desc_t             cur_reg;
    logic              busy_reg;
    logic [STEP_W-1:0] k_reg;
    logic [STEP_W-1:0] last_k_reg;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;
    logic              m_tlast_reg;

    logic [STEP_W-1:0] last_k;
    logic              emit;
    logic [31:0]       nx, ny;
    logic [62:0]       nstamp;
    logic [31:0]       cp_prod, cv_prod;
    logic [15:0]       ncp, ncv;

    always_comb begin
        if (cfg.result_count == 7'd0) begin
            last_k = '0;
        end else if (cfg.result_count > 7'(MAX_STEPS)) begin
            last_k = STEP_W'(MAX_STEPS - 1);
        end else begin
            last_k = STEP_W'(cfg.result_count - 7'd1);
        end
    end

    assign q_pop   = !busy_reg && q_valid;
    assign emit    = busy_reg && (!m_tvalid_reg || m_tready);
    assign nx      = cur_reg.px + cur_reg.dx;
    assign ny      = cur_reg.py + cur_reg.dy;
    assign nstamp  = cur_reg.stamp + {31'b0, cfg.step_dur};
    assign cp_prod = {16'b0, cur_reg.cpos} * {16'b0, cfg.decay};
    assign cv_prod = {16'b0, cur_reg.cvel} * {16'b0, cfg.decay};
    assign ncp     = (k_reg == '0) ? cur_reg.cpos : cp_prod[31:16];
    assign ncv     = (k_reg == '0) ? cur_reg.cvel : cv_prod[31:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            k_reg        <= '0;
        end else begin
            if (q_pop) begin
                cur_reg    <= q_data;
                k_reg      <= '0;
                last_k_reg <= last_k;
                busy_reg   <= 1'b1;
            end
            if (emit) begin
                m_tvalid_reg  <= 1'b1;
                m_tdata_reg   <= {3'b0, k_reg, nstamp, ncv, ncp, cur_reg.vy, cur_reg.vx,
                                  ny, nx};
                m_tlast_reg   <= (k_reg == last_k_reg);
                cur_reg.px    <= nx;
                cur_reg.py    <= ny;
                cur_reg.stamp <= nstamp;
                cur_reg.cpos  <= ncp;
                cur_reg.cvel  <= ncv;
                k_reg         <= k_reg + 1'b1;
                if (k_reg == last_k_reg) begin
                    busy_reg <= 1'b0;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ sv/constant_velocity_track_predictor_core.sv @@
// Top level of the constant-velocity track predictor: registers, front end, queue, back end.
//
// Each object beat yields a run of N prediction beats, N being result_count limited to
// 1..64, played out at one beat per cycle while the output is not stalled. The front
// end works out eleven products in turn through one shared multiplier, then runs two
// confidence dividers in parallel. The back end plays out one object's run while the
// front end works on the next; the input register and the two-entry queue absorb short
// bursts of objects.
module constant_velocity_track_predictor_core
    import cvtp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_addr,
    input  logic [31:0]      cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // start_x, start_y, speed_x, speed_y, var_pos_x, var_pos_y, var_vel_x, var_vel_y,
    // start_stamp_ns, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // pred_x, pred_y, pred_speed_x, pred_speed_y, position_confidence,
    // velocity_confidence, pred_stamp_ns, step_index, zero pad
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    cfg_t  cfg_reg;
    logic  q_push, q_full, q_valid, q_pop;
    desc_t q_wdata, q_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_time    <= 32'd6554;
            cfg_reg.step_dur     <= 32'd100000000;
            cfg_reg.result_count <= 7'd50;
            cfg_reg.accel_x      <= 32'd65536;
            cfg_reg.accel_y      <= 32'd65536;
            cfg_reg.ceiling      <= 32'd1310720;
            cfg_reg.decay        <= 16'd58982;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_STEP_TIME:    cfg_reg.step_time    <= cfg_wdata;
                REG_STEP_DUR:     cfg_reg.step_dur     <= cfg_wdata;
                REG_RESULT_COUNT: cfg_reg.result_count <= cfg_wdata[6:0];
                REG_ACCEL_X:      cfg_reg.accel_x      <= cfg_wdata;
                REG_ACCEL_Y:      cfg_reg.accel_y      <= cfg_wdata;
                REG_CEILING:      cfg_reg.ceiling      <= cfg_wdata;
                REG_DECAY:        cfg_reg.decay        <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    cvtp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_full   (q_full)
    );

    cvtp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .valid   (q_valid),
        .rdata   (q_rdata),
        .pop     (q_pop)
    );

    cvtp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ sv/cvtp_checker.sv @@
// Port-level checker of the track predictor core and its bind.
`include "constant_velocity_track_predictor_core_defines.svh"

module cvtp_checker
    import cvtp_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast
);

    `CVTP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `CVTP_ASSERT_NOW(a_max_run_last, m_tvalid && (m_tdata[228:223] == 6'd63), m_tlast)
    `CVTP_ASSERT_RST(a_reset_idle, !aresetn, !m_tvalid && s_tready)

endmodule

bind constant_velocity_track_predictor_core cvtp_checker u_cvtp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the constant-velocity track predictor core.
module testbench;
    import cvtp_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic [63:0] VAR_LIMIT = 64'h40_0000_0000;
    localparam logic [63:0] UNIT_Q16 = 64'h1_0000;
    localparam logic [63:0] FULL_CONF = 64'hFFFF;

    typedef struct {
        logic [31:0] px, py, vx, vy, vpx, vpy, vvx, vvy;
        logic [62:0] stamp;
    } track_t;

    typedef struct {
        logic [31:0] px, py, vx, vy;
        logic [15:0] cpos, cvel;
        logic [62:0] stamp;
        logic [5:0]  idx;
        logic        last;
    } forecast_t;

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             cfg_we = 0;
    logic [2:0]       cfg_addr = '0;
    logic [31:0]      cfg_wdata = '0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    forecast_t   forecasts[$];
    int          errors = 0;
    int          objects_sent = 0;
    int          beats_checked = 0;
    bit          send_gaps = 0;
    bit          sink_stalls = 0;

    logic [63:0] dt_q16 = 6554, dur_ns = 100000000, run_len = 50;
    logic [63:0] acc_x = 65536, acc_y = 65536, ceil_q16 = 1310720, decay_q16 = 58982;

    constant_velocity_track_predictor_core DUT (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d beats still expected", forecasts.size());
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [63:0] clamp_var(logic [63:0] v);
        return v > VAR_LIMIT ? VAR_LIMIT : v;
    endfunction

    function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
        logic [63:0] hi, lo;
        hi = a * (b >> 16);
        lo = (a * (b & 64'hFFFF)) >> 16;
        return clamp_var(hi + lo);
    endfunction

    function automatic logic [63:0] confidence(logic [63:0] mean);
        logic [63:0] q;
        if (mean <= UNIT_Q16) return FULL_CONF;
        if (mean >= ceil_q16) return 0;
        q = ((ceil_q16 - mean) << 16) / (ceil_q16 - UNIT_Q16);
        return q > FULL_CONF ? FULL_CONF : q;
    endfunction

    function automatic logic [31:0] advance(logic [31:0] speed);
        logic [63:0] s;
        s = {{32{speed[31]}}, speed};
        return 32'((s * dt_q16) >> 16);
    endfunction

    task automatic forecast_track(track_t t);
        logic [63:0] dt2, dt4, pxx, pyy, pvx, pvy, cp, cv, stamp;
        logic [31:0] dx, dy, px, py;
        int n;
        forecast_t f;
        dx = advance(t.vx);
        dy = advance(t.vy);
        dt2 = fix_mul(dt_q16, dt_q16);
        dt4 = fix_mul(fix_mul(dt2, dt_q16), dt_q16);
        pxx = clamp_var(t.vpx + fix_mul(dt2, t.vvx) + (fix_mul(dt4, acc_x) >> 2));
        pyy = clamp_var(t.vpy + fix_mul(dt2, t.vvy) + (fix_mul(dt4, acc_y) >> 2));
        pvx = clamp_var(t.vvx + fix_mul(dt2, acc_x));
        pvy = clamp_var(t.vvy + fix_mul(dt2, acc_y));
        cp = confidence((pxx + pyy) >> 1);
        cv = confidence((pvx + pvy) >> 1);
        n = run_len < 1 ? 1 : (run_len > MAX_STEPS ? MAX_STEPS : int'(run_len));
        px = t.px;
        py = t.py;
        stamp = {1'b0, t.stamp};
        for (int k = 0; k < n; k++) begin
            px += dx;
            py += dy;
            stamp = (stamp + dur_ns) & 64'h7FFF_FFFF_FFFF_FFFF;
            if (k > 0) begin
                cp = (cp * decay_q16) >> 16;
                cv = (cv * decay_q16) >> 16;
            end
            f.px = px;
            f.py = py;
            f.vx = t.vx;
            f.vy = t.vy;
            f.cpos = cp[15:0];
            f.cvel = cv[15:0];
            f.stamp = stamp[62:0];
            f.idx = k[5:0];
            f.last = (k == n - 1);
            forecasts.push_back(f);
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("Mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (forecasts.size() == 0) begin
                report("beat with nothing expected, tdata low word", m_tdata[63:0], 0);
            end else begin
                forecast_t f;
                f = forecasts.pop_front();
                beats_checked++;
                if (m_tdata[31:0] !== f.px) report("pred_x", m_tdata[31:0], f.px);
                if (m_tdata[63:32] !== f.py) report("pred_y", m_tdata[63:32], f.py);
                if (m_tdata[95:64] !== f.vx) report("pred_speed_x", m_tdata[95:64], f.vx);
                if (m_tdata[127:96] !== f.vy) report("pred_speed_y", m_tdata[127:96], f.vy);
                if (m_tdata[143:128] !== f.cpos)
                    report("position_confidence", m_tdata[143:128], f.cpos);
                if (m_tdata[159:144] !== f.cvel)
                    report("velocity_confidence", m_tdata[159:144], f.cvel);
                if (m_tdata[222:160] !== f.stamp)
                    report("pred_stamp_ns", m_tdata[222:160], f.stamp);
                if (m_tdata[228:223] !== f.idx) report("step_index", m_tdata[228:223], f.idx);
                if (m_tlast !== f.last) report("last_step", m_tlast, f.last);
            end
        end
    end

    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            n = sink_stalls ? $urandom_range(0, 11) : 0;
            if (n > 0) begin
                @(negedge aclk);
                m_tready <= 0;
                repeat (n - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_track(track_t t);
        int gap;
        gap = send_gaps ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= {1'b0, t.stamp, t.vvy, t.vvx, t.vpy, t.vpx, t.vy, t.vx, t.py, t.px};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        forecast_track(t);
        objects_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (forecasts.size() > 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        // A register only changes once every object sent so far has played out.
        s_tvalid <= 0;
        while (forecasts.size() > 0) @(negedge aclk);
        cfg_we <= 1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 0;
        case (addr)
            REG_STEP_TIME:    dt_q16 = value;
            REG_STEP_DUR:     dur_ns = value;
            REG_RESULT_COUNT: run_len = value & 32'h7F;
            REG_ACCEL_X:      acc_x = value;
            REG_ACCEL_Y:      acc_y = value;
            REG_CEILING:      ceil_q16 = value;
            REG_DECAY:        decay_q16 = value & 32'hFFFF;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_variance();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 32'h1_0000);
            1: return $urandom;
            default: return $urandom_range(0, 32'h28_0000);
        endcase
    endfunction

    function automatic track_t rand_track();
        track_t t;
        t.px = $urandom;
        t.py = $urandom;
        t.vx = $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 32'h40_0000)) -
            32'sh20_0000);
        t.vy = $urandom;
        t.vpx = rand_variance();
        t.vpy = rand_variance();
        t.vvx = rand_variance();
        t.vvy = rand_variance();
        t.stamp = 63'($urandom_range(0, 3) == 0 ? 63'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 1000)
            : {$urandom, $urandom});
        return t;
    endfunction

    task automatic test_field_extremes();
        track_t t;
        write_reg(REG_RESULT_COUNT, 3);
        t = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h0, 32'h0, 32'h0, 32'h0, 63'h7FFF_FFFF_FFFF_FFFF};
        send_track(t);
        t = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 63'h0};
        send_track(t);
        t = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h8_0000, 32'h2_0000,
              32'h14_0000, 32'h13_FFFF, 63'h5555_5555_5555_5555};
        send_track(t);
        t = '{32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
              32'hFFFF_FFFF, 63'h2AAA_AAAA_AAAA_AAAA};
        send_track(t);
        drain();
    endtask

    task automatic test_run_lengths();
        write_reg(REG_RESULT_COUNT, 0);
        send_track(rand_track());
        write_reg(REG_RESULT_COUNT, 1);
        send_track(rand_track());
        write_reg(REG_RESULT_COUNT, 64);
        send_track(rand_track());
        write_reg(REG_RESULT_COUNT, 32'hFFFF_FFFF);
        send_track(rand_track());
        drain();
        write_reg(REG_RESULT_COUNT, 65);
        send_track(rand_track());
        drain();
    endtask

    task automatic test_low_ceiling_and_zero_step();
        track_t t;
        write_reg(REG_RESULT_COUNT, 4);
        write_reg(REG_STEP_TIME, 0);
        write_reg(REG_CEILING, 32'h1_0000);
        t = '{32'h100, 32'h200, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000, 32'h1_0000,
              32'h0, 32'h2_0000, 63'h10};
        send_track(t);
        write_reg(REG_CEILING, 0);
        send_track(rand_track());
        write_reg(REG_CEILING, 32'hFFFF_FFFF);
        write_reg(REG_DECAY, 32'hFFFF);
        send_track(rand_track());
        write_reg(REG_UNUSED, 32'h1234_5678);
        send_track(rand_track());
        drain();
    endtask

    task automatic test_random(int count, bit stalls);
        send_gaps = stalls;
        sink_stalls = stalls;
        for (int i = 0; i < count; i++) begin
            send_track(rand_track());
            if (i == count / 2) drain();
        end
        drain();
    endtask

    task automatic set_random_config(int max_len);
        write_reg(REG_STEP_TIME, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h4_0000));
        write_reg(REG_STEP_DUR, $urandom);
        write_reg(REG_RESULT_COUNT, $urandom_range(1, max_len));
        write_reg(REG_ACCEL_X, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h8_0000));
        write_reg(REG_ACCEL_Y, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h8_0000));
        write_reg(REG_CEILING, $urandom_range(32'h1_0001, 32'h40_0000));
        write_reg(REG_DECAY, $urandom_range(0, 32'hFFFF));
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        test_field_extremes();
        send_gaps = 1;
        sink_stalls = 1;
        test_run_lengths();
        test_low_ceiling_and_zero_step();
        write_reg(REG_STEP_TIME, 32'hFFFF_FFFF);
        write_reg(REG_STEP_DUR, 32'hFFFF_FFFF);
        write_reg(REG_ACCEL_X, 32'hFFFF_FFFF);
        write_reg(REG_ACCEL_Y, 0);
        write_reg(REG_DECAY, 0);
        write_reg(REG_CEILING, 32'h1_0001);
        test_random(10, 1);
        write_reg(REG_STEP_TIME, 1);
        write_reg(REG_STEP_DUR, 1);
        write_reg(REG_ACCEL_X, 0);
        write_reg(REG_ACCEL_Y, 32'hFFFF_FFFF);
        test_random(10, 0);
        for (int phase = 0; phase < 8; phase++) begin
            set_random_config(phase == 3 ? 64 : 12);
            test_random(20, phase % 3 != 2);
        end
        repeat (100) @(negedge aclk);
        $display("Sent %0d objects and checked %0d prediction beats", objects_sent,
            beats_checked);
        $display("Covered run-length limits, ceiling and zero-step cases, and random configs");
        if (errors == 0 && forecasts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

@@ constant_velocity_track_predictor_core.f @@
+incdir+sv
sv/cvtp_pkg.sv
sv/cvtp_div.sv
sv/cvtp_front.sv
sv/cvtp_queue.sv
sv/cvtp_back.sv
sv/constant_velocity_track_predictor_core.sv
sv/cvtp_checker.sv
tb/testbench.sv
